// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by glyph_grid_atlas_placer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/gga_pkg.sv
// ----------------------------------------------------------------------------
// gga_pkg
// Types, constants and helper functions of the glyph grid atlas placer.
// ----------------------------------------------------------------------------
package gga_pkg;

    localparam int MAX_GLYPHS_DEF = 64;
    localparam int CELL_W         = 15;

    typedef struct packed {
        logic [7:0]         glyph_code;
        logic signed [11:0] pos_x;
        logic signed [11:0] pos_y;
        logic [9:0]         box_w;
        logic [9:0]         box_h;
        logic               final_glyph;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_code;
        logic [17:0] place_x;
        logic [17:0] place_y;
        logic [9:0]  out_w;
        logic [9:0]  out_h;
        logic [18:0] atlas_width;
        logic [18:0] atlas_height;
        logic        end_of_run;
    } t_out;

    typedef struct packed {
        logic [7:0]         code;
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic [9:0]         w;
        logic [9:0]         h;
    } t_glyph;

    typedef struct packed {
        logic [CELL_W-1:0]  cell_w;
        logic [CELL_W-1:0]  cell_h;
        logic signed [11:0] base_x;
        logic signed [11:0] base_y;
    } t_cell;

    typedef struct packed {
        logic upd;
        logic first;
        logic calc;
    } t_span_ctl;

    typedef enum logic [1:0] {
        S_LOAD,
        S_CALC,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_state state;
        logic   wr_en;
        logic   rd_en;
    } t_seq_stat;

    // Smallest power of two at or above v; zero maps to zero.
    function automatic logic [CELL_W-1:0] pow2_ceil(input logic [CELL_W-2:0] v);
        logic [CELL_W-2:0] m;
        m = v - 1'b1;
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        if (v == '0) begin
            return '0;
        end
        return {1'b0, m} + 1'b1;
    endfunction

endpackage

// File: rtl/glyph_grid_atlas_placer.sv
// ----------------------------------------------------------------------------
// glyph_grid_atlas_placer
// Collects a set of glyph boxes and places each one in a 16 by 16 grid atlas.
// ----------------------------------------------------------------------------
// Glyphs load at one beat per cycle while the input is not stalled into a
// single-port-write, single-port-read store of MAX_GLYPHS entries while the
// bounding box of the set is tracked; glyphs beyond MAX_GLYPHS are dropped.
// The beat marked final is followed by a state that sizes the grid cell, then
// the stored glyphs stream out in load order at up to one result per cycle
// while the output is not stalled, via the registered store read and result
// register. The input stays stalled until the last glyph enters the result
// register, which output stalls delay. The store needs no clearing after reset.
`include "assert_macros.svh"

module glyph_grid_atlas_placer #(
    parameter int MAX_GLYPHS = gga_pkg::MAX_GLYPHS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gga_pkg::t_in  i_in,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output gga_pkg::t_out o_out,
    output logic          o_out_valid,
    input  logic          i_out_stall
);
    import gga_pkg::*;

    localparam int ADDR_W = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;

    t_span_ctl         span_ctl;
    t_cell             grid;
    t_seq_stat         stat;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_glyph            wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    t_glyph            rd_data;

    gga_store #(
        .DEPTH  (MAX_GLYPHS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    gga_span u_span (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (span_ctl),
        .i_in    (i_in),
        .o_cell  (grid)
    );

    gga_seq #(
        .MAX_GLYPHS (MAX_GLYPHS),
        .ADDR_W     (ADDR_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out       (o_out),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cell      (grid),
        .o_span_ctl  (span_ctl),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_stat      (stat)
    );

    `ASSERT_SAME(a_no_load_during_emit, i_clk, i_rst_n, stat.wr_en, !stat.rd_en,
        "Store written and read in the same cycle.")
    `ASSERT_NEXT(a_final_starts_calc, i_clk, i_rst_n,
        i_in_valid && !o_in_stall && i_in.final_glyph, stat.state == S_CALC,
        "Final beat did not start cell sizing.")
    `ASSERT_NEXT(a_calc_then_emit, i_clk, i_rst_n, stat.state == S_CALC,
        stat.state == S_EMIT, "Cell sizing not followed by emission.")
    `ASSERT_SAME(a_read_only_in_emit, i_clk, i_rst_n, stat.rd_en,
        stat.state == S_EMIT, "Store read outside emission.")

endmodule

// File: rtl/gga_store.sv
// ----------------------------------------------------------------------------
// gga_store
// Glyph store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gga_store #(
    parameter int DEPTH  = gga_pkg::MAX_GLYPHS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [ADDR_W-1:0]  i_wr_addr,
    input  gga_pkg::t_glyph    i_wr_data,
    input  logic               i_rd_en,
    input  logic [ADDR_W-1:0]  i_rd_addr,
    output gga_pkg::t_glyph    o_rd_data
);
    import gga_pkg::*;

    t_glyph r_mem [DEPTH];
    t_glyph r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/gga_span.sv
// ----------------------------------------------------------------------------
// gga_span
// Bounding box tracker of the glyph set and grid cell sizing.
// ----------------------------------------------------------------------------
module gga_span (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gga_pkg::t_span_ctl i_ctl,
    input  gga_pkg::t_in       i_in,
    output gga_pkg::t_cell     o_cell
);
    import gga_pkg::*;

    logic signed [11:0] r_min_x, n_min_x;
    logic signed [11:0] r_min_y, n_min_y;
    logic signed [12:0] r_max_x, n_max_x;
    logic signed [12:0] r_max_y, n_max_y;
    t_cell              r_cell, n_cell;

    logic signed [12:0] ex;
    logic signed [12:0] ey;
    logic [12:0]        span_w;
    logic [12:0]        span_h;

    always_comb begin
        ex     = $signed({i_in.pos_x[11], i_in.pos_x}) + $signed({3'b000, i_in.box_w});
        ey     = $signed({i_in.pos_y[11], i_in.pos_y}) + $signed({3'b000, i_in.box_h});
        span_w = 13'(r_max_x - $signed({r_min_x[11], r_min_x}));
        span_h = 13'(r_max_y - $signed({r_min_y[11], r_min_y}));

        n_min_x = r_min_x;
        n_min_y = r_min_y;
        n_max_x = r_max_x;
        n_max_y = r_max_y;
        if (i_ctl.upd) begin
            if (i_ctl.first || (i_in.pos_x < r_min_x)) begin
                n_min_x = i_in.pos_x;
            end
            if (i_ctl.first || (i_in.pos_y < r_min_y)) begin
                n_min_y = i_in.pos_y;
            end
            if (i_ctl.first || (ex > r_max_x)) begin
                n_max_x = ex;
            end
            if (i_ctl.first || (ey > r_max_y)) begin
                n_max_y = ey;
            end
        end

        n_cell = r_cell;
        if (i_ctl.calc) begin
            n_cell.cell_w = pow2_ceil({span_w, 1'b0});
            n_cell.cell_h = pow2_ceil({1'b0, span_h} + 14'd2);
            n_cell.base_x = r_min_x;
            n_cell.base_y = r_min_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= '0;
            r_min_y <= '0;
            r_max_x <= '0;
            r_max_y <= '0;
        end else begin
            r_min_x <= n_min_x;
            r_min_y <= n_min_y;
            r_max_x <= n_max_x;
            r_max_y <= n_max_y;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    assign o_cell = r_cell;

endmodule

// File: rtl/gga_seq.sv
// ----------------------------------------------------------------------------
// gga_seq
// Load and emit sequencer: store addressing, read stage and result register.
// ----------------------------------------------------------------------------
module gga_seq #(
    parameter int MAX_GLYPHS = gga_pkg::MAX_GLYPHS_DEF,
    parameter int ADDR_W     = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gga_pkg::t_in       i_in,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output gga_pkg::t_out      o_out,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  gga_pkg::t_cell     i_cell,
    output gga_pkg::t_span_ctl o_span_ctl,
    output logic               o_wr_en,
    output logic [ADDR_W-1:0]  o_wr_addr,
    output gga_pkg::t_glyph    o_wr_data,
    output logic               o_rd_en,
    output logic [ADDR_W-1:0]  o_rd_addr,
    input  gga_pkg::t_glyph    i_rd_data,
    output gga_pkg::t_seq_stat o_stat
);
    import gga_pkg::*;

    localparam int CNT_W = $clog2(MAX_GLYPHS + 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_rd_addr, n_rd_addr;
    logic             r_rd_vld, n_rd_vld;
    logic             r_rd_last, n_rd_last;
    logic             r_out_vld, n_out_vld;
    t_out             r_out, n_out;

    logic             load_beat;
    logic             store_ok;
    logic             wr_en;
    logic             move;
    logic             rd_issue;
    logic             emit_done;
    logic             in_stall;
    logic             calc;
    logic             emit;
    logic [17:0]      off_x;
    logic [17:0]      off_y;
    logic [12:0]      dx;
    logic [12:0]      dy;

    always_comb begin
        in_stall = 1'b1;
        calc     = 1'b0;
        emit     = 1'b0;
        case (r_state)
            S_LOAD: in_stall = 1'b0;
            S_CALC: calc     = 1'b1;
            S_EMIT: emit     = 1'b1;
            default: in_stall = 1'b1;
        endcase
    end

    always_comb begin
        load_beat = i_in_valid && !in_stall;
        store_ok  = r_count < CNT_W'(MAX_GLYPHS);
        wr_en     = load_beat && store_ok;
        move      = r_rd_vld && (!r_out_vld || !i_out_stall);
        rd_issue  = emit && (r_rd_addr != r_count) && (!r_rd_vld || move);
        emit_done = move && r_rd_last;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (load_beat && i_in.final_glyph) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: n_state = S_EMIT;
            S_EMIT: begin
                if (emit_done) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_rd_addr = r_rd_addr;
        n_rd_vld  = r_rd_vld;
        n_rd_last = r_rd_last;
        if (wr_en) begin
            n_count = r_count + 1'b1;
        end
        if (move) begin
            n_rd_vld = 1'b0;
        end
        if (rd_issue) begin
            n_rd_vld  = 1'b1;
            n_rd_last = (r_rd_addr + 1'b1) == r_count;
            n_rd_addr = r_rd_addr + 1'b1;
        end
        if (emit_done) begin
            n_count   = '0;
            n_rd_addr = '0;
        end
    end

    always_comb begin
        dx    = 13'($signed({i_rd_data.x[11], i_rd_data.x})
                    - $signed({i_cell.base_x[11], i_cell.base_x}));
        dy    = 13'($signed({i_rd_data.y[11], i_rd_data.y})
                    - $signed({i_cell.base_y[11], i_cell.base_y}));
        off_x = 18'(i_rd_data.code[3:0]) * 18'(i_cell.cell_w);
        off_y = 18'(i_rd_data.code[7:4]) * 18'(i_cell.cell_h);

        n_out_vld = r_out_vld && i_out_stall;
        n_out     = r_out;
        if (move) begin
            n_out_vld          = 1'b1;
            n_out.out_code     = i_rd_data.code;
            n_out.place_x      = off_x + 18'(dx);
            n_out.place_y      = off_y + 18'(dy);
            n_out.out_w        = i_rd_data.w;
            n_out.out_h        = i_rd_data.h;
            n_out.atlas_width  = {i_cell.cell_w, 4'b0000};
            n_out.atlas_height = {i_cell.cell_h, 4'b0000};
            n_out.end_of_run   = r_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_rd_addr <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_addr <= n_rd_addr;
            r_rd_vld  <= n_rd_vld;
            r_rd_last <= n_rd_last;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_in_stall       = in_stall;
    assign o_out            = r_out;
    assign o_out_valid      = r_out_vld;
    assign o_span_ctl.upd   = wr_en;
    assign o_span_ctl.first = r_count == '0;
    assign o_span_ctl.calc  = calc;
    assign o_wr_en          = wr_en;
    assign o_wr_addr        = r_count[ADDR_W-1:0];
    assign o_wr_data.code   = i_in.glyph_code;
    assign o_wr_data.x      = i_in.pos_x;
    assign o_wr_data.y      = i_in.pos_y;
    assign o_wr_data.w      = i_in.box_w;
    assign o_wr_data.h      = i_in.box_h;
    assign o_rd_en          = rd_issue;
    assign o_rd_addr        = r_rd_addr[ADDR_W-1:0];
    assign o_stat.state     = r_state;
    assign o_stat.wr_en     = wr_en;
    assign o_stat.rd_en     = rd_issue;

endmodule
